@@ src/sofx_pkg.sv @@
package sofx_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int TAPS_W    = 7;
  localparam int GAIN_W    = 16;
  localparam int REG_IDX_W = 2;

  // datapath widths
  localparam int A_W     = 32;
  localparam int B_W     = 18;
  localparam int PROD_W  = A_W + B_W;
  localparam int ACC_W   = 34;
  localparam int FM_W    = 18;
  localparam int RECT_W  = 18;
  localparam int Y_W     = 17;
  localparam int SOFT_W  = 17;
  localparam int Q1_W    = 17;
  localparam int PROC_W  = 17;

  localparam int UNITY        = 32768;
  localparam int SUB_ON_LEVEL = 328;
  localparam int K_DELAYED    = 9830;
  localparam int K_SMOOTH     = 3277;
  localparam int K_KEEP       = 29491;
  localparam int K_SCALE      = 22938;
  localparam int K_CLIP       = 21846;
  localparam int FM_MAX       = 131071;
  localparam int FM_MIN       = -131072;
  localparam int OUT_MAX      = 32767;
  localparam int OUT_MIN      = -32768;

  // y^3 / (3 * 2^30): shift by 30 after adding half the divisor, then
  // divide by 3 as a multiply by ceil(2^17 / 3) and a shift by 17
  localparam int CUBE_SH   = 30;
  localparam logic [PROD_W-1:0] CUBE_HALF = PROD_W'(3) << (CUBE_SH - 1);
  localparam int RECIP3    = 43691;
  localparam int RECIP_SH  = 17;

  localparam logic [TAPS_W-1:0] DELAY_TAPS_RST = TAPS_W'(51);
  localparam logic [GAIN_W-1:0] SUB_LEVEL_RST  = GAIN_W'(9830);
  localparam logic [GAIN_W-1:0] DRIVE_GAIN_RST = GAIN_W'(24576);
  localparam logic [GAIN_W-1:0] WET_MIX_RST    = GAIN_W'(32768);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DELAY_TAPS = 2'd0,
    REG_SUB_LEVEL  = 2'd1,
    REG_DRIVE_GAIN = 2'd2,
    REG_WET_MIX    = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    A_DLY, A_FM, A_RECT, A_Y, A_PROD, A_Q1, A_SOFT, A_X, A_SUB, A_PROC
  } asel_t;

  typedef enum logic [3:0] {
    B_K_DELAYED, B_K_KEEP, B_K_SMOOTH, B_DRIVE, B_Y, B_RECIP3, B_K_SCALE,
    B_DRY_SL, B_SL, B_DRY_WM, B_WM
  } bsel_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_RECT, OP_LOAD, OP_FILT, OP_YCLIP, OP_CUBEQ, OP_SOFT, OP_SUB,
    OP_PROC, OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_IF_OFF, JMP_DONE
  } jmp_t;

  typedef enum logic {
    SEQ_IDLE, SEQ_RUN
  } seq_state_t;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_MIX  = 5'd13;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd17;

  typedef struct packed {
    asel_t             a_sel;
    bsel_t             b_sel;
    op_t               op;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   en;
  } ctl_t;

  typedef struct packed {
    logic [GAIN_W-1:0] drive;
    logic [GAIN_W-1:0] sl;
    logic [GAIN_W-1:0] dry_sl;
    logic [GAIN_W-1:0] wm;
    logic [GAIN_W-1:0] dry_wm;
  } mix_cfg_t;

  // Microprogram. Each step issues one product; the op field consumes the
  // product issued by the step before.
  function automatic uword_t ucode(input logic [STEP_W-1:0] pc);
    uword_t uw;
    unique case (pc)
      5'd0:    uw = '{A_DLY,  B_K_DELAYED, OP_NOP,   JMP_IF_OFF, STEP_MIX};
      5'd1:    uw = '{A_FM,   B_K_KEEP,    OP_RECT,  JMP_NEXT,   '0};
      5'd2:    uw = '{A_RECT, B_K_SMOOTH,  OP_LOAD,  JMP_NEXT,   '0};
      5'd3:    uw = '{A_FM,   B_DRIVE,     OP_FILT,  JMP_NEXT,   '0};
      5'd4:    uw = '{A_FM,   B_DRIVE,     OP_NOP,   JMP_NEXT,   '0};
      5'd5:    uw = '{A_Y,    B_Y,         OP_YCLIP, JMP_NEXT,   '0};
      5'd6:    uw = '{A_Y,    B_Y,         OP_NOP,   JMP_NEXT,   '0};
      5'd7:    uw = '{A_PROD, B_Y,         OP_NOP,   JMP_NEXT,   '0};
      5'd8:    uw = '{A_Q1,   B_RECIP3,    OP_CUBEQ, JMP_NEXT,   '0};
      5'd9:    uw = '{A_Q1,   B_RECIP3,    OP_NOP,   JMP_NEXT,   '0};
      5'd10:   uw = '{A_SOFT, B_K_SCALE,   OP_SOFT,  JMP_NEXT,   '0};
      5'd11:   uw = '{A_SOFT, B_K_SCALE,   OP_NOP,   JMP_NEXT,   '0};
      5'd12:   uw = '{A_X,    B_DRY_SL,    OP_SUB,   JMP_NEXT,   '0};
      5'd13:   uw = '{A_X,    B_DRY_SL,    OP_NOP,   JMP_NEXT,   '0};
      5'd14:   uw = '{A_SUB,  B_SL,        OP_LOAD,  JMP_NEXT,   '0};
      5'd15:   uw = '{A_X,    B_DRY_WM,    OP_PROC,  JMP_NEXT,   '0};
      5'd16:   uw = '{A_PROC, B_WM,        OP_LOAD,  JMP_NEXT,   '0};
      5'd17:   uw = '{A_PROC, B_WM,        OP_OUT,   JMP_DONE,   '0};
      default: uw = '{A_X,    B_WM,        OP_NOP,   JMP_DONE,   '0};
    endcase
    return uw;
  endfunction

  // Arithmetic shift right with round to nearest, ties away from zero.
  function automatic logic signed [PROD_W-1:0] rnd_shift(
    input logic signed [PROD_W-1:0] v,
    input int                       sh
  );
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    r   = (mag + (PROD_W'(1) << (sh - 1))) >> sh;
    return v[PROD_W-1] ? -signed'(r) : signed'(r);
  endfunction

endpackage

@@ src/sofx_in_if.sv @@
interface sofx_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sofx_pkg::SAMPLE_W-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

@@ src/sofx_out_if.sv @@
interface sofx_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sofx_pkg::SAMPLE_W-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

@@ src/sofx_cfg_if.sv @@
interface sofx_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sofx_pkg::REG_IDX_W-1:0]      index;
  logic [sofx_pkg::GAIN_W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/subharmonic_octave_effect.sv @@
// Subharmonic octave effect: one Q1.15 sample in, one Q1.15 sample out.
//
// samp_in  : input transactions (valid/ready, in_sample).
// samp_out : result transactions (valid/ready, out_sample), one per input.
// cfg      : register writes (index, data); always ready. Write only while
//            no sample is in flight. 0 delay_taps, 1 sub_level,
//            2 drive_gain, 3 wet_mix; data bits above a register's width drop.
//
// A small microprogram drives one shared 32x18 multiplier; every product is
// registered and taken by the next step. With sub_level at 328 or more a
// sample runs 18 steps; below that the subharmonic steps, which hold the
// multiplier chain of the rectifier, low-pass, drive and cubic clip, are
// skipped. The next input is taken only once the program has finished.
// The result sits in an output register, so a new input is accepted while
// it waits; a second result stalls the program at its last step until
// samp_out takes the first. Reset clears the ring position, the fill count
// that stands in for a cleared delay store, the filter memory and the
// registers to their defaults; no clearing pass is needed.
module subharmonic_octave_effect #(
  parameter int DELAY_DEPTH = 128
) (
  input logic        clk,
  input logic        rst,
  sofx_in_if.sink    samp_in,
  sofx_out_if.source samp_out,
  sofx_cfg_if.sink   cfg
);

  logic [sofx_pkg::TAPS_W-1:0]          delay_taps;
  logic [sofx_pkg::GAIN_W-1:0]          sub_level;
  logic [sofx_pkg::GAIN_W-1:0]          drive_gain;
  logic [sofx_pkg::GAIN_W-1:0]          wet_mix;

  logic                                 accept;
  logic                                 busy;
  logic                                 sub_on;
  logic                                 res_fire;
  logic                                 out_valid;
  logic signed [sofx_pkg::SAMPLE_W-1:0] out_sample;
  logic signed [sofx_pkg::SAMPLE_W-1:0] dly;
  logic signed [sofx_pkg::SAMPLE_W-1:0] res;
  logic [sofx_pkg::GAIN_W-1:0]          sl_eff;
  logic [sofx_pkg::GAIN_W-1:0]          wm_eff;
  sofx_pkg::ctl_t                       ctl;
  sofx_pkg::mix_cfg_t                   mix_cfg;

  // ---- configuration registers ----
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_taps <= sofx_pkg::DELAY_TAPS_RST;
      sub_level  <= sofx_pkg::SUB_LEVEL_RST;
      drive_gain <= sofx_pkg::DRIVE_GAIN_RST;
      wet_mix    <= sofx_pkg::WET_MIX_RST;
    end else if (cfg.valid) begin
      unique case (sofx_pkg::reg_idx_t'(cfg.index))
        sofx_pkg::REG_DELAY_TAPS: delay_taps <= cfg.data[sofx_pkg::TAPS_W-1:0];
        sofx_pkg::REG_SUB_LEVEL:  sub_level  <= cfg.data;
        sofx_pkg::REG_DRIVE_GAIN: drive_gain <= cfg.data;
        sofx_pkg::REG_WET_MIX:    wet_mix    <= cfg.data;
        default: ;
      endcase
    end
  end

  // gains above unity act as unity
  assign sl_eff = (sub_level > sofx_pkg::GAIN_W'(sofx_pkg::UNITY))
                  ? sofx_pkg::GAIN_W'(sofx_pkg::UNITY) : sub_level;
  assign wm_eff = (wet_mix > sofx_pkg::GAIN_W'(sofx_pkg::UNITY))
                  ? sofx_pkg::GAIN_W'(sofx_pkg::UNITY) : wet_mix;
  assign sub_on = (sl_eff >= sofx_pkg::GAIN_W'(sofx_pkg::SUB_ON_LEVEL));

  assign mix_cfg.drive  = drive_gain;
  assign mix_cfg.sl     = sl_eff;
  assign mix_cfg.dry_sl = sofx_pkg::GAIN_W'(sofx_pkg::UNITY) - sl_eff;
  assign mix_cfg.wm     = wm_eff;
  assign mix_cfg.dry_wm = sofx_pkg::GAIN_W'(sofx_pkg::UNITY) - wm_eff;

  // ---- input side ----
  assign samp_in.ready = !busy;
  assign accept        = samp_in.valid && !busy;

  // ring store: delayed sample read and new sample written on accept
  sofx_delay #(
    .DEPTH (DELAY_DEPTH)
  ) u_delay (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (samp_in.in_sample),
    .taps    (delay_taps),
    .rd_data (dly)
  );

  sofx_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .sub_on    (sub_on),
    .out_valid (out_valid),
    .out_ready (samp_out.ready),
    .busy      (busy),
    .ctl       (ctl)
  );

  sofx_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .ctl   (ctl),
    .cfg   (mix_cfg),
    .x_in  (samp_in.in_sample),
    .dly   (dly),
    .res   (res)
  );

  // ---- output register ----
  assign res_fire = ctl.en && (ctl.uw.op == sofx_pkg::OP_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (samp_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_sample <= res;
    end
  end

  assign samp_out.valid      = out_valid;
  assign samp_out.out_sample = out_sample;

endmodule

@@ src/sofx_delay.sv @@
module sofx_delay #(
  parameter int DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic signed [sofx_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [sofx_pkg::TAPS_W-1:0]          taps,
  output logic signed [sofx_pkg::SAMPLE_W-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic signed [sofx_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic signed [sofx_pkg::SAMPLE_W-1:0] rd_q;
  logic                                 rd_ok;
  logic [AW-1:0]                        wr_ptr;
  logic [AW-1:0]                        fill;   // writes so far, held at DEPTH-1
  logic [AW-1:0]                        taps_w;
  logic                                 taps_ok;
  logic [AW:0]                          diff;
  logic [AW-1:0]                        rd_addr;

  assign taps_w  = AW'(taps);
  assign taps_ok = (taps != '0) && (int'(taps) < DEPTH);
  assign diff    = {1'b0, wr_ptr} - {1'b0, taps_w};
  assign rd_addr = diff[AW] ? AW'(diff + (AW+1)'(DEPTH)) : diff[AW-1:0];

  // entry behind the pointer was written once fill has reached the tap count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      fill   <= '0;
      rd_ok  <= 1'b0;
    end else if (wr_en) begin
      wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (fill != AW'(DEPTH - 1)) begin
        fill <= fill + 1'b1;
      end
      rd_ok <= taps_ok && (fill >= taps_w);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
      rd_q        <= mem[rd_addr];
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

@@ src/sofx_seq.sv @@
module sofx_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               sub_on,
  input  logic               out_valid,
  input  logic               out_ready,
  output logic               busy,
  output sofx_pkg::ctl_t     ctl
);

  sofx_pkg::seq_state_t             state;
  sofx_pkg::seq_state_t             state_next;
  logic [sofx_pkg::STEP_W-1:0]      pc;
  logic [sofx_pkg::STEP_W-1:0]      pc_next;
  sofx_pkg::uword_t                 uw;
  logic                             stall;

  assign uw    = sofx_pkg::ucode(pc);
  assign busy  = (state == sofx_pkg::SEQ_RUN);
  // result step waits while the output register still holds a result
  assign stall = (uw.op == sofx_pkg::OP_OUT) && out_valid && !out_ready;

  assign ctl.uw = uw;
  assign ctl.en = busy && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sofx_pkg::SEQ_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    unique case (state)
      sofx_pkg::SEQ_IDLE: begin
        if (start) begin
          state_next = sofx_pkg::SEQ_RUN;
          pc_next    = '0;
        end
      end
      sofx_pkg::SEQ_RUN: begin
        if (!stall) begin
          unique case (uw.jmp)
            sofx_pkg::JMP_NEXT:   pc_next = pc + 1'b1;
            sofx_pkg::JMP_IF_OFF: pc_next = sub_on ? pc + 1'b1 : uw.target;
            sofx_pkg::JMP_DONE:   state_next = sofx_pkg::SEQ_IDLE;
            default:              state_next = sofx_pkg::SEQ_IDLE;
          endcase
        end
      end
      default: state_next = sofx_pkg::SEQ_IDLE;
    endcase
  end

  a_start_pc0: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && (pc == '0))
    else $error("sequencer did not start at step 0");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    busy && stall |=> busy && $stable(pc))
    else $error("sequencer moved while result stalled");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= sofx_pkg::LAST_STEP)
    else $error("step counter past end of program");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    busy && !stall && (uw.jmp == sofx_pkg::JMP_DONE) |=> !busy)
    else $error("sequencer did not finish after last step");

endmodule

@@ src/sofx_dp.sv @@
module sofx_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  sofx_pkg::ctl_t                       ctl,
  input  sofx_pkg::mix_cfg_t                   cfg,
  input  logic signed [sofx_pkg::SAMPLE_W-1:0] x_in,
  input  logic signed [sofx_pkg::SAMPLE_W-1:0] dly,
  output logic signed [sofx_pkg::SAMPLE_W-1:0] res
);

  localparam int PW = sofx_pkg::PROD_W;

  logic signed [sofx_pkg::SAMPLE_W-1:0] x;
  logic signed [sofx_pkg::FM_W-1:0]     fm;
  logic signed [sofx_pkg::RECT_W-1:0]   rect;
  logic signed [sofx_pkg::Y_W-1:0]      y;
  logic                                 clip;
  logic [sofx_pkg::Q1_W-1:0]            q1;
  logic                                 cneg;
  logic signed [sofx_pkg::SOFT_W-1:0]   shaped;
  logic signed [sofx_pkg::SAMPLE_W-1:0] sub;
  logic signed [sofx_pkg::PROC_W-1:0]   proc;
  logic signed [sofx_pkg::ACC_W-1:0]    acc;
  logic signed [PW-1:0]                 prod;

  logic signed [sofx_pkg::A_W-1:0]      a_op;
  logic signed [sofx_pkg::B_W-1:0]      b_op;
  logic signed [PW-1:0]                 prod_r15;
  logic signed [PW-1:0]                 prod_r12;
  logic signed [PW-1:0]                 acc_sum;
  logic signed [PW-1:0]                 sum_r15;
  logic signed [sofx_pkg::RECT_W-1:0]   dsum;
  logic [sofx_pkg::RECT_W-1:0]          dmag;
  logic signed [sofx_pkg::RECT_W:0]     rect_w;
  logic signed [sofx_pkg::FM_W-1:0]     fm_next;
  logic [PW-1:0]                        cmag;
  logic [PW-1:0]                        ct;
  logic signed [sofx_pkg::SOFT_W-1:0]   qd;

  always_comb begin
    unique case (ctl.uw.a_sel)
      sofx_pkg::A_DLY:  a_op = sofx_pkg::A_W'(dly);
      sofx_pkg::A_FM:   a_op = sofx_pkg::A_W'(fm);
      sofx_pkg::A_RECT: a_op = sofx_pkg::A_W'(rect);
      sofx_pkg::A_Y:    a_op = sofx_pkg::A_W'(y);
      sofx_pkg::A_PROD: a_op = signed'(prod[sofx_pkg::A_W-1:0]);
      sofx_pkg::A_Q1:   a_op = signed'(sofx_pkg::A_W'(q1));
      sofx_pkg::A_SOFT: a_op = sofx_pkg::A_W'(shaped);
      sofx_pkg::A_X:    a_op = sofx_pkg::A_W'(x);
      sofx_pkg::A_SUB:  a_op = sofx_pkg::A_W'(sub);
      sofx_pkg::A_PROC: a_op = sofx_pkg::A_W'(proc);
      default:          a_op = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.uw.b_sel)
      sofx_pkg::B_K_DELAYED: b_op = sofx_pkg::B_W'(sofx_pkg::K_DELAYED);
      sofx_pkg::B_K_KEEP:    b_op = sofx_pkg::B_W'(sofx_pkg::K_KEEP);
      sofx_pkg::B_K_SMOOTH:  b_op = sofx_pkg::B_W'(sofx_pkg::K_SMOOTH);
      sofx_pkg::B_DRIVE:     b_op = signed'(sofx_pkg::B_W'(cfg.drive));
      sofx_pkg::B_Y:         b_op = sofx_pkg::B_W'(y);
      sofx_pkg::B_RECIP3:    b_op = sofx_pkg::B_W'(sofx_pkg::RECIP3);
      sofx_pkg::B_K_SCALE:   b_op = sofx_pkg::B_W'(sofx_pkg::K_SCALE);
      sofx_pkg::B_DRY_SL:    b_op = signed'(sofx_pkg::B_W'(cfg.dry_sl));
      sofx_pkg::B_SL:        b_op = signed'(sofx_pkg::B_W'(cfg.sl));
      sofx_pkg::B_DRY_WM:    b_op = signed'(sofx_pkg::B_W'(cfg.dry_wm));
      sofx_pkg::B_WM:        b_op = signed'(sofx_pkg::B_W'(cfg.wm));
      default:               b_op = '0;
    endcase
  end

  assign prod_r15 = sofx_pkg::rnd_shift(prod, 15);
  assign prod_r12 = sofx_pkg::rnd_shift(prod, 12);
  assign acc_sum  = PW'(acc) + prod;
  assign sum_r15  = sofx_pkg::rnd_shift(acc_sum, 15);

  // x + 0.3 * delayed, full-wave rectified, doubled, minus one
  assign dsum   = sofx_pkg::RECT_W'(x) + prod_r15[sofx_pkg::RECT_W-1:0];
  assign dmag   = dsum[sofx_pkg::RECT_W-1] ? sofx_pkg::RECT_W'(-dsum)
                                           : sofx_pkg::RECT_W'(dsum);
  assign rect_w = signed'({dmag, 1'b0}) - (sofx_pkg::RECT_W+1)'(sofx_pkg::UNITY);

  always_comb begin
    if (sum_r15 > sofx_pkg::FM_MAX) begin
      fm_next = sofx_pkg::FM_W'(sofx_pkg::FM_MAX);
    end else if (sum_r15 < sofx_pkg::FM_MIN) begin
      fm_next = sofx_pkg::FM_W'(sofx_pkg::FM_MIN);
    end else begin
      fm_next = sum_r15[sofx_pkg::FM_W-1:0];
    end
  end

  // cube magnitude plus half of 3 * 2^30
  assign cmag = prod[PW-1] ? PW'(-prod) : PW'(prod);
  assign ct   = cmag + sofx_pkg::CUBE_HALF;
  assign qd   = signed'(sofx_pkg::SOFT_W'(prod >>> sofx_pkg::RECIP_SH));

  always_comb begin
    if (sum_r15 > sofx_pkg::OUT_MAX) begin
      res = sofx_pkg::SAMPLE_W'(sofx_pkg::OUT_MAX);
    end else if (sum_r15 < sofx_pkg::OUT_MIN) begin
      res = sofx_pkg::SAMPLE_W'(sofx_pkg::OUT_MIN);
    end else begin
      res = sum_r15[sofx_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fm <= '0;
    end else if (ctl.en && (ctl.uw.op == sofx_pkg::OP_FILT)) begin
      fm <= fm_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= x_in;
      sub <= '0;
    end else if (ctl.en) begin
      prod <= a_op * b_op;
      unique case (ctl.uw.op)
        sofx_pkg::OP_RECT: rect <= rect_w[sofx_pkg::RECT_W-1:0];
        sofx_pkg::OP_LOAD: acc  <= sofx_pkg::ACC_W'(prod);
        sofx_pkg::OP_YCLIP: begin
          if (prod_r12 > sofx_pkg::UNITY) begin
            clip   <= 1'b1;
            shaped <= sofx_pkg::SOFT_W'(sofx_pkg::K_CLIP);
          end else if (prod_r12 < -sofx_pkg::UNITY) begin
            clip   <= 1'b1;
            shaped <= sofx_pkg::SOFT_W'(-sofx_pkg::K_CLIP);
          end else begin
            clip <= 1'b0;
            y    <= prod_r12[sofx_pkg::Y_W-1:0];
          end
        end
        sofx_pkg::OP_CUBEQ: begin
          cneg <= prod[PW-1];
          q1   <= sofx_pkg::Q1_W'(ct >> sofx_pkg::CUBE_SH);
        end
        sofx_pkg::OP_SOFT: begin
          if (!clip) begin
            shaped <= y - (cneg ? -qd : qd);
          end
        end
        sofx_pkg::OP_SUB:  sub  <= prod_r15[sofx_pkg::SAMPLE_W-1:0];
        sofx_pkg::OP_PROC: proc <= sum_r15[sofx_pkg::PROC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ bench/sofx_output_check.sv @@
`timescale 1ns / 1ps

// Watches the sample channels and register writes, predicts each output
// sample and compares it against what the block delivers.
module sofx_output_check #(
  parameter int DEPTH = 128
) (
  input  logic clk,
  input  logic rst,
  sofx_in_if   samp_in,
  sofx_out_if  samp_out,
  sofx_cfg_if  cfg,
  output int   err_count,
  output int   due_count
);

  // shadow of the block state
  logic signed [sofx_pkg::SAMPLE_W-1:0] ring [DEPTH];
  int                                   wr_ptr;
  longint                               lp_mem;
  logic [sofx_pkg::TAPS_W-1:0]          taps;
  logic [sofx_pkg::GAIN_W-1:0]          sub_level;
  logic [sofx_pkg::GAIN_W-1:0]          drive_gain;
  logic [sofx_pkg::GAIN_W-1:0]          wet_mix;

  logic signed [sofx_pkg::SAMPLE_W-1:0] out_samples_due [$];
  int                                   errors = 0;
  int                                   due_q  = 0;

  assign err_count = errors;
  assign due_count = due_q;

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    errors++;
  endtask

  // Round v / d to nearest, ties away from zero.
  function automatic longint div_round(input longint v, input longint d);
    if (v >= 0) return (v + d / 2) / d;
    return -((-v + d / 2) / d);
  endfunction

  task automatic predict_out_sample(input logic signed [sofx_pkg::SAMPLE_W-1:0] x_in);
    longint x, dly, sub, sl, wm, sum, mag, rect, fm, y, shaped, mixed, res;
    x   = longint'(x_in);
    dly = 0;
    sub = 0;
    sl  = (sub_level > sofx_pkg::UNITY) ? longint'(sofx_pkg::UNITY)
                                        : longint'(sub_level);
    wm  = (wet_mix > sofx_pkg::UNITY) ? longint'(sofx_pkg::UNITY)
                                      : longint'(wet_mix);

    if (taps != 0 && int'(taps) < DEPTH)
      dly = longint'(ring[(wr_ptr + DEPTH - int'(taps)) % DEPTH]);
    ring[wr_ptr] = x_in;
    wr_ptr = (wr_ptr + 1) % DEPTH;

    if (sl >= sofx_pkg::SUB_ON_LEVEL) begin
      sum  = x + div_round(dly * sofx_pkg::K_DELAYED, sofx_pkg::UNITY);
      mag  = (sum < 0) ? -sum : sum;
      rect = 2 * mag - sofx_pkg::UNITY;
      fm   = div_round(rect * sofx_pkg::K_SMOOTH + lp_mem * sofx_pkg::K_KEEP,
                       sofx_pkg::UNITY);
      if (fm > sofx_pkg::FM_MAX) fm = longint'(sofx_pkg::FM_MAX);
      if (fm < sofx_pkg::FM_MIN) fm = longint'(sofx_pkg::FM_MIN);
      lp_mem = fm;
      y = div_round(fm * longint'(drive_gain), 4096);
      if (y > sofx_pkg::UNITY) shaped = longint'(sofx_pkg::K_CLIP);
      else if (y < -sofx_pkg::UNITY) shaped = -longint'(sofx_pkg::K_CLIP);
      else shaped = y - div_round(y * y * y, longint'(3) << 30);
      sub = div_round(shaped * sofx_pkg::K_SCALE, sofx_pkg::UNITY);
    end

    mixed = div_round(x * (sofx_pkg::UNITY - sl) + sub * sl, sofx_pkg::UNITY);
    res   = div_round(x * (sofx_pkg::UNITY - wm) + mixed * wm, sofx_pkg::UNITY);
    if (res > sofx_pkg::OUT_MAX) res = longint'(sofx_pkg::OUT_MAX);
    if (res < sofx_pkg::OUT_MIN) res = longint'(sofx_pkg::OUT_MIN);
    out_samples_due.push_back(sofx_pkg::SAMPLE_W'(res));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (ring[i]) ring[i] = '0;
      wr_ptr     = 0;
      lp_mem     = 0;
      taps       = sofx_pkg::DELAY_TAPS_RST;
      sub_level  = sofx_pkg::SUB_LEVEL_RST;
      drive_gain = sofx_pkg::DRIVE_GAIN_RST;
      wet_mix    = sofx_pkg::WET_MIX_RST;
      out_samples_due.delete();
    end else begin
      if (samp_out.valid && samp_out.ready) begin
        if (out_samples_due.size() == 0) begin
          report_mismatch($sformatf("output %0d with no sample outstanding",
                                    samp_out.out_sample));
        end else begin
          logic signed [sofx_pkg::SAMPLE_W-1:0] want;
          want = out_samples_due.pop_front();
          if (samp_out.out_sample !== want)
            report_mismatch($sformatf("out_sample %0d, expected %0d",
                                      samp_out.out_sample, want));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (sofx_pkg::reg_idx_t'(cfg.index))
          sofx_pkg::REG_DELAY_TAPS: taps       = cfg.data[sofx_pkg::TAPS_W-1:0];
          sofx_pkg::REG_SUB_LEVEL:  sub_level  = cfg.data;
          sofx_pkg::REG_DRIVE_GAIN: drive_gain = cfg.data;
          sofx_pkg::REG_WET_MIX:    wet_mix    = cfg.data;
          default: ;
        endcase
      end
      if (samp_in.valid && samp_in.ready) predict_out_sample(samp_in.in_sample);
    end
    due_q <= out_samples_due.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the subharmonic octave effect. The output check
// module beside the block does all prediction and comparison; this module
// only drives transactions, throttles both channels and reports the result.
module testbench;

  localparam int DEPTH = 128;
  // Each item spends a sample run in the block, random idle gaps on each
  // side and register phases. ~1000 items stay well under this.
  localparam int unsigned LIMIT = 400_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          err_count;
  int          due_count;
  int unsigned cycle_count = 0;
  bit          idling = 1'b1;  // random gaps on both sides while set

  sofx_in_if  samp_in ();
  sofx_out_if samp_out ();
  sofx_cfg_if cfg ();

  subharmonic_octave_effect #(.DELAY_DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .samp_in  (samp_in),
    .samp_out (samp_out),
    .cfg      (cfg)
  );

  sofx_output_check #(.DEPTH(DEPTH)) out_check (
    .clk       (clk),
    .rst       (rst),
    .samp_in   (samp_in),
    .samp_out  (samp_out),
    .cfg       (cfg),
    .err_count (err_count),
    .due_count (due_count)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost output ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("** subharmonic_octave_effect: FAILED **");
      $finish;
    end
  end

  // Output side back-pressure: random stall bursts, otherwise ready
  // stays high. One assignment to ready per edge.
  always begin
    @(posedge clk);
    if (idling && $urandom_range(0, 5) == 0) begin
      samp_out.ready <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    samp_out.ready <= 1'b1;
  end

  // Mostly full-scale noise, with rail values and quiet passages mixed in.
  function automatic logic signed [sofx_pkg::SAMPLE_W-1:0] pick_sample();
    logic signed [sofx_pkg::SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = 16'sh7FFF;
      1:       s = 16'sh8000;
      2, 3:    s = sofx_pkg::SAMPLE_W'($urandom_range(0, 1023)) - 16'sd512;
      default: s = sofx_pkg::SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  // Leaves valid high after the transaction so back-to-back samples
  // don't toggle it; the caller drops it at the end of a run.
  task automatic send_sample(input logic signed [sofx_pkg::SAMPLE_W-1:0] s);
    if (idling && $urandom_range(0, 3) == 0) begin
      samp_in.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    samp_in.valid     <= 1'b1;
    samp_in.in_sample <= s;
    @(posedge clk);
    while (!samp_in.ready) @(posedge clk);
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_sample(pick_sample());
    samp_in.valid <= 1'b0;
  endtask

  // Every sample yields an output, so an empty scoreboard means the block
  // is idle and register writes are safe.
  task automatic wait_idle();
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  // Same as send_sample: valid stays up across consecutive writes.
  task automatic write_reg(input sofx_pkg::reg_idx_t idx,
                           input logic [sofx_pkg::GAIN_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic apply_settings(input int taps,
                                input int sl,
                                input int drive,
                                input int wm);
    wait_idle();
    write_reg(sofx_pkg::REG_DELAY_TAPS, sofx_pkg::GAIN_W'(taps));
    write_reg(sofx_pkg::REG_SUB_LEVEL, sofx_pkg::GAIN_W'(sl));
    write_reg(sofx_pkg::REG_DRIVE_GAIN, sofx_pkg::GAIN_W'(drive));
    write_reg(sofx_pkg::REG_WET_MIX, sofx_pkg::GAIN_W'(wm));
    cfg.valid <= 1'b0;
  endtask

  // Random register set, weighted toward the range edges. The delay write
  // sometimes carries junk above bit 6 to check that it drops.
  task automatic random_settings();
    int taps, sl, drive, wm;
    case ($urandom_range(0, 5))
      0:       taps = 0;
      1:       taps = 1;
      2:       taps = 127;
      3:       taps = $urandom_range(0, 16'hFFFF);
      default: taps = $urandom_range(1, 101);
    endcase
    case ($urandom_range(0, 5))
      0:       sl = $urandom_range(0, sofx_pkg::SUB_ON_LEVEL - 1);  // sub path off
      1:       sl = sofx_pkg::SUB_ON_LEVEL;
      2:       sl = sofx_pkg::UNITY;
      3:       sl = $urandom_range(sofx_pkg::UNITY + 1, 16'hFFFF);
      default: sl = $urandom_range(sofx_pkg::SUB_ON_LEVEL, sofx_pkg::UNITY);
    endcase
    case ($urandom_range(0, 4))
      0:       drive = 4096;
      1:       drive = 45056;
      2:       drive = $urandom_range(0, 16'hFFFF);
      default: drive = $urandom_range(4096, 45056);
    endcase
    case ($urandom_range(0, 4))
      0:       wm = 0;
      1:       wm = sofx_pkg::UNITY;
      2:       wm = $urandom_range(sofx_pkg::UNITY + 1, 16'hFFFF);
      default: wm = $urandom_range(0, sofx_pkg::UNITY);
    endcase
    apply_settings(taps, sl, drive, wm);
  endtask

  initial begin
    samp_in.valid     <= 1'b0;
    samp_in.in_sample <= '0;
    samp_out.ready    <= 1'b0;
    cfg.valid         <= 1'b0;
    cfg.index         <= sofx_pkg::REG_DELAY_TAPS;
    cfg.data          <= '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, rails and near-zero
    send_sample(16'sd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    samp_in.valid <= 1'b0;

    // shortest delay, full blend, max nominal drive: clipper saturates
    apply_settings(1, sofx_pkg::UNITY, 45056, sofx_pkg::UNITY);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sd16384);
    samp_in.valid <= 1'b0;

    // just under the threshold (sub path off, filter held), zero delay,
    // wet above unity
    apply_settings(0, sofx_pkg::SUB_ON_LEVEL - 1, 24576, 16'hFFFF);
    send_sample(16'sd12345);
    send_sample(16'sh8000);
    samp_in.valid <= 1'b0;

    // exactly on the threshold, longest delay the register holds, unity drive
    apply_settings(127, sofx_pkg::SUB_ON_LEVEL, 4096, sofx_pkg::UNITY);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sd0);
    samp_in.valid <= 1'b0;

    // blend above unity, fully dry, drive at its register max
    apply_settings(51, 16'hFFFF, 16'hFFFF, 0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    samp_in.valid <= 1'b0;

    // sub path off entirely, half wet, zero drive
    apply_settings(101, 0, 0, 16384);
    send_sample(16'sd1000);
    send_sample(-16'sd1000);
    samp_in.valid <= 1'b0;

    // random settings per run, throttled on both sides
    repeat (7) begin
      random_settings();
      send_noise(110);
    end

    // closing run at full rate
    random_settings();
    idling = 1'b0;
    send_noise(160);

    wait_idle();
    repeat (25) @(posedge clk);  // catch any stray output past the last one
    if (err_count == 0) begin
      $display("** subharmonic_octave_effect: PASSED **");
    end else begin
      $display("** subharmonic_octave_effect: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sofx_pkg.sv
src/sofx_in_if.sv
src/sofx_out_if.sv
src/sofx_cfg_if.sv
src/sofx_delay.sv
src/sofx_seq.sv
src/sofx_dp.sv
src/subharmonic_octave_effect.sv
bench/sofx_output_check.sv
bench/testbench.sv
